// ===== src/lett_pkg.sv =====
// lett_pkg: shared types and constants of the lane edge tracker.
// Used by lett_front, lett_queue, lett_back and lane_edge_tracker_top.
// No dependencies.
`default_nettype none

package lett_pkg;

    // default frame geometry
    localparam int ROWS_DEF = 144;
    localparam int COLS_DEF = 256;

    // register reset values
    localparam logic [7:0] END_ROW_RST      = 8'd30;
    localparam logic [6:0] LOOK_OFFSET_RST  = 7'd15;
    localparam logic [6:0] SEARCH_RANGE_RST = 7'd15;
    localparam logic [7:0] JUMP_LIMIT_RST   = 8'd20;
    localparam logic [7:0] BAND_START_RST   = 8'd40;
    localparam logic [7:0] BAND_END_RST     = 8'd30;
    localparam int         MID_RST          = 127;

    // register indexes on the config port
    typedef enum logic [2:0] {
        CFG_END_ROW      = 3'd0,
        CFG_LOOK_OFFSET  = 3'd1,
        CFG_SEARCH_RANGE = 3'd2,
        CFG_JUMP_LIMIT   = 3'd3,
        CFG_BAND_START   = 3'd4,
        CFG_BAND_END     = 3'd5
    } cfg_index_t;

    // edge status codes
    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_FALL = 2'd1;
    localparam logic [1:0] ST_PREF = 2'd2;

    // one search job: settings captured at the last pixel of a frame
    typedef struct packed {
        logic [7:0] end_row;
        logic [8:0] look;
        logic [6:0] rng;
        logic [7:0] jump;
        logic [7:0] band_start;
        logic [7:0] band_end;
    } job_t;

endpackage

`default_nettype wire

// ===== src/lett_ram.sv =====
// lett_ram: generic single write port, single read port RAM, registered read.
// No dependencies.
`default_nettype none

module lett_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/lett_queue.sv =====
// lett_queue: two-entry job queue between the pixel front end and the search engine.
// Depends on lett_pkg (job_t).
`default_nettype none

module lett_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lett_pkg::job_t push_job,
    input  logic          pop,
    output lett_pkg::job_t pop_job,
    output logic          empty
);
    import lett_pkg::*;

    job_t       slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;

    // storage
    always_ff @(posedge clk)
    begin
        if (push && cnt_reg != 2'd2)
        begin
            slot_reg[wptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push && cnt_reg != 2'd2)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop && cnt_reg != 2'd0)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if ((push && cnt_reg != 2'd2) && !(pop && cnt_reg != 2'd0))
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (!(push && cnt_reg != 2'd2) && (pop && cnt_reg != 2'd0))
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    assign pop_job = slot_reg[rptr_reg];
    assign empty   = (cnt_reg == 2'd0);

endmodule

`default_nettype wire

// ===== src/lett_front.sv =====
// lett_front: config registers, pixel beat intake and frame store writes;
// raises a search job on the last pixel. Depends on lett_pkg.
`default_nettype none

module lett_front #(
    parameter int ROWS = lett_pkg::ROWS_DEF,
    parameter int COLS = lett_pkg::COLS_DEF,
    localparam int AW = $clog2(ROWS * COLS)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [7:0]     pixel_value,
    input  logic           frame_end,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [7:0]     cfg_data,
    input  logic           busy,
    input  logic           q_empty,
    output logic           wr_en,
    output logic [AW-1:0]  wr_addr,
    output logic           wr_data,
    output logic           push,
    output lett_pkg::job_t job
);
    import lett_pkg::*;

    localparam int NPIX = ROWS * COLS;
    localparam int CNTW = $clog2(NPIX + 1);

    logic [CNTW-1:0] cnt_reg;
    logic [7:0]      end_row_reg;
    logic [6:0]      look_off_reg;
    logic [6:0]      rng_reg;
    logic [7:0]      jump_reg;
    logic [7:0]      band_start_reg;
    logic [7:0]      band_end_reg;
    logic            accept;

    // frame store is busy while a search runs or is queued
    assign in_stall  = busy || !q_empty;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;

    // store write: pixels past a full frame are dropped
    assign wr_en   = accept && (cnt_reg < CNTW'(NPIX));
    assign wr_addr = AW'(cnt_reg);
    assign wr_data = (pixel_value != 8'd0);
    assign push    = accept && frame_end;

    assign job.end_row    = end_row_reg;
    assign job.look       = {1'b0, end_row_reg} + {2'b00, look_off_reg};
    assign job.rng        = rng_reg;
    assign job.jump       = jump_reg;
    assign job.band_start = band_start_reg;
    assign job.band_end   = band_end_reg;

    // pixel counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                cnt_reg <= '0;
            end
            else if (cnt_reg < CNTW'(NPIX))
            begin
                cnt_reg <= cnt_reg + CNTW'(1);
            end
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_row_reg    <= END_ROW_RST;
            look_off_reg   <= LOOK_OFFSET_RST;
            rng_reg        <= SEARCH_RANGE_RST;
            jump_reg       <= JUMP_LIMIT_RST;
            band_start_reg <= BAND_START_RST;
            band_end_reg   <= BAND_END_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_END_ROW:      end_row_reg    <= cfg_data;
                CFG_LOOK_OFFSET:  look_off_reg   <= cfg_data[6:0];
                CFG_SEARCH_RANGE: rng_reg        <= cfg_data[6:0];
                CFG_JUMP_LIMIT:   jump_reg       <= cfg_data;
                CFG_BAND_START:   band_start_reg <= cfg_data;
                CFG_BAND_END:     band_end_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/lett_back.sv =====
// lett_back: search sequencer. Walks the frame store row by row for the lane
// edges, filters the midline, tests the corner band, holds the result beat.
// Depends on lett_pkg.
`default_nettype none

module lett_back #(
    parameter int ROWS = lett_pkg::ROWS_DEF,
    parameter int COLS = lett_pkg::COLS_DEF,
    localparam int AW = $clog2(ROWS * COLS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  lett_pkg::job_t   q_job,
    output logic             pop,
    output logic             busy,
    output logic [AW-1:0]    rd_addr,
    input  logic             rd_data,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       left_edge,
    output logic [7:0]       right_edge,
    output logic signed [9:0] mid_column,
    output logic [1:0]       left_status,
    output logic [1:0]       right_status,
    output logic             corner_found
);
    import lett_pkg::*;

    localparam int CW = $clog2(COLS);
    localparam int SW = (CW + 4 > 12) ? CW + 4 : 12;
    localparam int RW = $clog2(ROWS);
    localparam logic signed [SW-1:0] HI   = SW'(COLS - 1);
    localparam logic signed [SW-1:0] HALF = SW'(COLS / 2);
    localparam logic signed [SW-1:0] ZERO = '0;
    localparam logic [AW-1:0] BOT_BASE = AW'((ROWS - 1) * COLS);
    localparam logic [AW-1:0] ROW_STEP = AW'(COLS);
    localparam logic [RW-1:0] ROW_TOP  = RW'(ROWS - 1);
    localparam logic [RW-1:0] ROW_NEXT = RW'(ROWS - 2);
    localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_BOT    = 14'b00000000000010,
        S_CHK    = 14'b00000000000100,
        S_A      = 14'b00000000001000,
        S_B      = 14'b00000000010000,
        S_END    = 14'b00000000100000,
        S_BOTEND = 14'b00000001000000,
        S_ROWCHK = 14'b00000010000000,
        S_ROWSET = 14'b00000100000000,
        S_FIN1   = 14'b00001000000000,
        S_FIN2   = 14'b00010000000000,
        S_FIN3   = 14'b00100000000000,
        S_CRN    = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } state_t;

    // which edge scan is running
    typedef enum logic [2:0] {
        K_BL = 3'd0,
        K_BR = 3'd1,
        K_LP = 3'd2,
        K_LF = 3'd3,
        K_RP = 3'd4,
        K_RF = 3'd5
    } kind_t;

    state_t state_reg;
    job_t   job_reg;
    kind_t  kind_reg;

    logic [RW-1:0] row_reg;
    logic [AW-1:0] base_reg;
    logic [CW-1:0] crn_col_reg;
    logic          pend_reg;
    logic          corner_reg;

    logic signed [SW-1:0] bl_reg, br_reg, lw_reg, last_reg;
    logic [1:0]           bls_reg, brs_reg, lst_reg, rst_reg;
    logic signed [SW-1:0] lmax_reg, ls_reg, rmax_reg, rmin_reg, rs_reg;
    logic signed [SW-1:0] l_reg, r_reg, mid_reg;
    logic signed [SW-1:0] sc_c_reg, sc_lim_reg;
    logic                 sc_dn_reg, found_reg, a_reg;
    logic signed [SW-1:0] ol_reg, or_reg, om_reg;
    logic [1:0]           ols_reg, ors_reg;

    logic                 out_valid_reg;
    logic [7:0]           left_reg, right_reg;
    logic signed [9:0]    mid_out_reg;
    logic [1:0]           lsto_reg, rsto_reg;
    logic                 corner_out_reg;

    logic signed [SW-1:0] rng_s, jump_s;
    logic signed [SW-1:0] bl_p, bl_m, br_p, br_m;
    logic signed [SW-1:0] lmax_c, lmin_c, ls_c, rmax_c, rmin_c, rs_c;
    logic signed [SW-1:0] step_c, step2_c, col_c;
    logic signed [SW-1:0] diff_c, sum_c, half_c;
    logic signed [SW-1:0] mclamp_c, dlt_c, absd_c, newmid_c, lcl_c, rcl_c;
    logic [CW-1:0]        col_u;
    logic                 row_above_end, row_is_look, crn_live, crn_in_band;

    function automatic logic signed [SW-1:0] clamp_col(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] res;
        res = v;
        if (v < ZERO)
        begin
            res = ZERO;
        end
        else if (v > HI)
        begin
            res = HI;
        end
        return res;
    endfunction

    function automatic logic in_range(input logic signed [SW-1:0] c,
                                      input logic signed [SW-1:0] lim,
                                      input logic dn);
        return dn ? (c > lim) : (c < lim);
    endfunction

    assign rng_s  = SW'($signed({1'b0, job_reg.rng}));
    assign jump_s = SW'($signed({1'b0, job_reg.jump}));

    // search windows for the next row
    always_comb
    begin
        bl_p = bl_reg + rng_s;
        bl_m = bl_reg - rng_s;
        br_p = br_reg + rng_s;
        br_m = br_reg - rng_s;
        if (bls_reg == ST_NONE)
        begin
            if (brs_reg != ST_NONE)
            begin
                lmax_c = clamp_col(br_p - lw_reg);
                lmin_c = clamp_col(br_m - lw_reg);
                ls_c   = clamp_col(br_reg - lw_reg);
            end
            else
            begin
                lmax_c = HALF;
                lmin_c = ZERO;
                ls_c   = HALF;
            end
        end
        else
        begin
            lmax_c = (bl_p > HI) ? HI : bl_p;
            lmin_c = (bl_m < ZERO) ? ZERO : bl_m;
            ls_c   = bl_reg;
        end
        if (brs_reg == ST_NONE)
        begin
            if (bls_reg != ST_NONE)
            begin
                rmax_c = clamp_col(bl_p + lw_reg);
                rmin_c = clamp_col(bl_m + lw_reg);
                rs_c   = clamp_col(bl_reg + lw_reg);
            end
            else
            begin
                rmax_c = HI;
                rmin_c = HALF;
                rs_c   = HALF;
            end
        end
        else
        begin
            rmax_c = (br_p > HI) ? HI : br_p;
            rmin_c = (br_m < ZERO) ? ZERO : br_m;
            rs_c   = br_reg;
        end
    end

    // scan stepping and read address
    always_comb
    begin
        step_c  = sc_dn_reg ? sc_c_reg - SW'(1) : sc_c_reg + SW'(1);
        step2_c = sc_dn_reg ? sc_c_reg - SW'(2) : sc_c_reg + SW'(2);
        col_c   = sc_c_reg;
        if (state_reg == S_A)
        begin
            col_c = step_c;
        end
        else if (state_reg == S_B)
        begin
            col_c = step2_c;
        end
        col_u = (state_reg == S_CRN) ? crn_col_reg : col_c[CW-1:0];
    end

    assign rd_addr = base_reg + AW'(col_u);

    // midline arithmetic, C style truncating halve
    always_comb
    begin
        diff_c   = r_reg - l_reg;
        sum_c    = diff_c + SW'(diff_c[SW-1]);
        half_c   = sum_c >>> 1;
        mclamp_c = (mid_reg < l_reg) ? l_reg : ((mid_reg > r_reg) ? r_reg : mid_reg);
        dlt_c    = mclamp_c - last_reg;
        absd_c   = (dlt_c < ZERO) ? -dlt_c : dlt_c;
        newmid_c = (absd_c > jump_s) ? last_reg : mclamp_c;
        lcl_c    = (l_reg < ZERO) ? ZERO : l_reg;
        rcl_c    = (r_reg > HI) ? HI : r_reg;
    end

    assign row_above_end = 16'(row_reg) > 16'(job_reg.end_row);
    assign row_is_look   = 16'(row_reg) == 16'(job_reg.look);
    assign crn_live      = 16'(row_reg) > 16'(job_reg.band_end);
    assign crn_in_band   = 16'(row_reg) <= 16'(job_reg.band_start);

    assign pop  = (state_reg == S_IDLE) && !q_empty;
    assign busy = (state_reg != S_IDLE);

    // job capture
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= q_job;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= K_BL;
            bl_reg        <= ZERO;
            br_reg        <= ZERO;
            bls_reg       <= ST_NONE;
            brs_reg       <= ST_NONE;
            lw_reg        <= ZERO;
            last_reg      <= SW'(MID_RST);
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= S_BOT;
                    end
                end
                // bottom row, scan left from centre
                S_BOT:
                begin
                    bl_reg     <= ZERO;
                    br_reg     <= HI;
                    bls_reg    <= ST_NONE;
                    brs_reg    <= ST_NONE;
                    ol_reg     <= ZERO;
                    or_reg     <= HI;
                    om_reg     <= HALF;
                    ols_reg    <= ST_NONE;
                    ors_reg    <= ST_NONE;
                    corner_reg <= 1'b1;
                    base_reg   <= BOT_BASE;
                    sc_c_reg   <= HALF;
                    sc_lim_reg <= ZERO;
                    sc_dn_reg  <= 1'b1;
                    kind_reg   <= K_BL;
                    state_reg  <= S_CHK;
                end
                S_CHK:
                begin
                    if (in_range(sc_c_reg, sc_lim_reg, sc_dn_reg))
                    begin
                        state_reg <= S_A;
                    end
                    else
                    begin
                        found_reg <= 1'b0;
                        state_reg <= S_END;
                    end
                end
                S_A:
                begin
                    a_reg     <= rd_data;
                    state_reg <= S_B;
                end
                // compare neighbor pair, then slide one column
                S_B:
                begin
                    if (a_reg != rd_data)
                    begin
                        found_reg <= 1'b1;
                        state_reg <= S_END;
                    end
                    else
                    begin
                        a_reg    <= rd_data;
                        sc_c_reg <= step_c;
                        if (!in_range(step_c, sc_lim_reg, sc_dn_reg))
                        begin
                            found_reg <= 1'b0;
                            state_reg <= S_END;
                        end
                    end
                end
                // scan finished: record and pick the next scan
                S_END:
                begin
                    unique case (kind_reg)
                        K_BL:
                        begin
                            if (found_reg)
                            begin
                                bl_reg  <= sc_c_reg;
                                bls_reg <= ST_PREF;
                            end
                            sc_c_reg   <= HALF;
                            sc_lim_reg <= HI;
                            sc_dn_reg  <= 1'b0;
                            kind_reg   <= K_BR;
                            state_reg  <= S_CHK;
                        end
                        K_BR:
                        begin
                            if (found_reg)
                            begin
                                br_reg  <= sc_c_reg;
                                brs_reg <= ST_PREF;
                            end
                            state_reg <= S_BOTEND;
                        end
                        K_LP:
                        begin
                            if (found_reg)
                            begin
                                l_reg      <= sc_c_reg;
                                lst_reg    <= ST_PREF;
                                sc_c_reg   <= rs_reg;
                                sc_lim_reg <= rmax_reg;
                                sc_dn_reg  <= 1'b0;
                                kind_reg   <= K_RP;
                            end
                            else
                            begin
                                sc_c_reg   <= ls_reg;
                                sc_lim_reg <= lmax_reg;
                                sc_dn_reg  <= 1'b0;
                                kind_reg   <= K_LF;
                            end
                            state_reg <= S_CHK;
                        end
                        K_LF:
                        begin
                            if (found_reg)
                            begin
                                l_reg   <= sc_c_reg;
                                lst_reg <= ST_FALL;
                            end
                            sc_c_reg   <= rs_reg;
                            sc_lim_reg <= rmax_reg;
                            sc_dn_reg  <= 1'b0;
                            kind_reg   <= K_RP;
                            state_reg  <= S_CHK;
                        end
                        K_RP:
                        begin
                            if (found_reg)
                            begin
                                r_reg     <= sc_c_reg;
                                rst_reg   <= ST_PREF;
                                state_reg <= S_FIN1;
                            end
                            else
                            begin
                                sc_c_reg   <= rs_reg;
                                sc_lim_reg <= rmin_reg;
                                sc_dn_reg  <= 1'b1;
                                kind_reg   <= K_RF;
                                state_reg  <= S_CHK;
                            end
                        end
                        K_RF:
                        begin
                            if (found_reg)
                            begin
                                r_reg   <= sc_c_reg;
                                rst_reg <= ST_FALL;
                            end
                            state_reg <= S_FIN1;
                        end
                        default:
                        begin
                            state_reg <= S_FIN1;
                        end
                    endcase
                end
                // bottom row may itself be the look row
                S_BOTEND:
                begin
                    if (16'(ROW_TOP) == 16'(job_reg.look))
                    begin
                        ol_reg  <= bl_reg;
                        or_reg  <= br_reg;
                        ols_reg <= bls_reg;
                        ors_reg <= brs_reg;
                    end
                    row_reg   <= ROW_NEXT;
                    base_reg  <= base_reg - ROW_STEP;
                    state_reg <= S_ROWCHK;
                end
                S_ROWCHK:
                begin
                    if (row_above_end)
                    begin
                        state_reg <= S_ROWSET;
                    end
                    else
                    begin
                        row_reg     <= ROW_TOP;
                        base_reg    <= BOT_BASE;
                        crn_col_reg <= '0;
                        pend_reg    <= 1'b0;
                        state_reg   <= S_CRN;
                    end
                end
                // set windows, start the preferred left scan
                S_ROWSET:
                begin
                    lmax_reg   <= lmax_c;
                    ls_reg     <= ls_c;
                    rmax_reg   <= rmax_c;
                    rmin_reg   <= rmin_c;
                    rs_reg     <= rs_c;
                    l_reg      <= ZERO;
                    r_reg      <= HI;
                    lst_reg    <= ST_NONE;
                    rst_reg    <= ST_NONE;
                    sc_c_reg   <= ls_c;
                    sc_lim_reg <= lmin_c;
                    sc_dn_reg  <= 1'b1;
                    kind_reg   <= K_LP;
                    state_reg  <= S_CHK;
                end
                // width measure, edge inference from the width, or the row below's edges
                S_FIN1:
                begin
                    if (lst_reg != ST_NONE && rst_reg != ST_NONE)
                    begin
                        lw_reg <= r_reg - l_reg;
                    end
                    else if (lst_reg != ST_NONE)
                    begin
                        r_reg <= l_reg + lw_reg;
                    end
                    else if (rst_reg != ST_NONE)
                    begin
                        l_reg <= r_reg - lw_reg;
                    end
                    else
                    begin
                        l_reg <= bl_reg;
                        r_reg <= br_reg;
                    end
                    state_reg <= S_FIN2;
                end
                S_FIN2:
                begin
                    mid_reg   <= l_reg + half_c;
                    state_reg <= S_FIN3;
                end
                // jump filter and commit the row
                S_FIN3:
                begin
                    last_reg <= newmid_c;
                    bl_reg   <= lcl_c;
                    br_reg   <= rcl_c;
                    bls_reg  <= lst_reg;
                    brs_reg  <= rst_reg;
                    if (row_is_look)
                    begin
                        ol_reg  <= lcl_c;
                        or_reg  <= rcl_c;
                        om_reg  <= newmid_c;
                        ols_reg <= lst_reg;
                        ors_reg <= rst_reg;
                    end
                    row_reg   <= row_reg - RW'(1);
                    base_reg  <= base_reg - ROW_STEP;
                    state_reg <= S_ROWCHK;
                end
                // corner band: one pixel read per cycle
                S_CRN:
                begin
                    if (pend_reg && rd_data)
                    begin
                        corner_reg <= 1'b0;
                    end
                    if (crn_live)
                    begin
                        if (crn_in_band)
                        begin
                            pend_reg <= 1'b1;
                            if (crn_col_reg == COL_LAST)
                            begin
                                crn_col_reg <= '0;
                                row_reg     <= row_reg - RW'(1);
                                base_reg    <= base_reg - ROW_STEP;
                            end
                            else
                            begin
                                crn_col_reg <= crn_col_reg + CW'(1);
                            end
                        end
                        else
                        begin
                            pend_reg <= 1'b0;
                            row_reg  <= row_reg - RW'(1);
                            base_reg <= base_reg - ROW_STEP;
                        end
                    end
                    else
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= S_OUT;
                    end
                end
                // result beat into the output register
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
        begin
            left_reg       <= 8'(clamp_col(ol_reg));
            right_reg      <= 8'(clamp_col(or_reg));
            mid_out_reg    <= 10'(om_reg);
            lsto_reg       <= ols_reg;
            rsto_reg       <= ors_reg;
            corner_out_reg <= corner_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign left_edge    = left_reg;
    assign right_edge   = right_reg;
    assign mid_column   = mid_out_reg;
    assign left_status  = lsto_reg;
    assign right_status = rsto_reg;
    assign corner_found = corner_out_reg;

endmodule

`default_nettype wire

// ===== src/lane_edge_tracker_top.sv =====
// lane_edge_tracker_top: lane boundary row search over a binary edge frame.
// Depends on lett_pkg, lett_ram, lett_front, lett_queue, lett_back.
//
//  channel   direction  handshake               payload
//  in        sink       in_valid / in_stall     pixel_value, frame_end
//  out       source     out_valid / out_stall   left_edge .. corner_found
//  cfg       sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Pixels load one per cycle, while in_stall is low, into a one-bit frame store
// (ROWS*COLS entries). After the last pixel the search engine owns the store's
// read port: it scans the bottom row, then each row above it whose index
// exceeds end_row (half-frame windows when neither edge of the row below was
// found), then reads the corner band pixel by pixel.
// in_stall is high while a search job waits or runs; the result register lets
// the next frame load while out_stall holds the previous result. No clearing pass.
`default_nettype none

module lane_edge_tracker_top #(
    parameter int ROWS = lett_pkg::ROWS_DEF,
    parameter int COLS = lett_pkg::COLS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        pixel_value,
    input  logic              frame_end,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        left_edge,
    output logic [7:0]        right_edge,
    output logic signed [9:0] mid_column,
    output logic [1:0]        left_status,
    output logic [1:0]        right_status,
    output logic              corner_found,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data
);
    import lett_pkg::*;

    localparam int AW = $clog2(ROWS * COLS);

    logic          busy, q_empty, push, pop;
    logic          wr_en, wr_data, rd_data;
    logic [AW-1:0] wr_addr, rd_addr;
    job_t          push_job, pop_job;

    // intake
    lett_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_value (pixel_value),
        .frame_end   (frame_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .busy        (busy),
        .q_empty     (q_empty),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .push        (push),
        .job         (push_job)
    );

    // frame store
    lett_ram #(.WIDTH(1), .DEPTH(ROWS * COLS)) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // job queue
    lett_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    // search engine
    lett_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_job        (pop_job),
        .pop          (pop),
        .busy         (busy),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_edge    (left_edge),
        .right_edge   (right_edge),
        .mid_column   (mid_column),
        .left_status  (left_status),
        .right_status (right_status),
        .corner_found (corner_found)
    );

endmodule

`default_nettype wire
